/* src/sss_pkg.sv */
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants of the span sum stack
// Word types of the input and result channels, the classified job word
// passed from front to back, and the fixed field constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int FIELD_W = 20;

  // parameter defaults
  localparam int STACK_DEPTH_DEF = 128;
  localparam int COUNT_BITS_DEF  = 20;

  // job queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FIELD_W-1:0] SUM_MODULUS = FIELD_W'(1000000);
  localparam logic [FIELD_W-1:0] POS_MAX     = '1;
  localparam logic [FIELD_W-1:0] OUT_MAX     = '1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      first;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] covered;
    logic [FIELD_W-1:0] total;
    logic               overflow;
  } out_t;

  // item class set by the front
  typedef enum logic [1:0] {
    K_FIRST,
    K_NEWMAX,
    K_NORMAL
  } kind_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    kind_t                     kind;
    logic [FIELD_W-1:0]        span;
  } job_t;

  // back end sequencer
  typedef enum logic [1:0] {
    B_IDLE,
    B_POP,
    B_RED,
    B_ADD
  } b_state_t;

endpackage

`default_nettype wire

/* src/sss_ram.sv */
// ----------------------------------------------------------------------------
// sss_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sss_front.sv */
// ----------------------------------------------------------------------------
// sss_front: input stage of the span sum stack
// Accepts input words, tracks the running maximum and position, and tags
// each word as sequence start, new maximum or ordinary value.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_front #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire sss_pkg::in_t in_data,
  input  wire logic         q_full,
  output logic              q_push,
  output sss_pkg::job_t     q_job
);

  import sss_pkg::*;

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

  logic signed [VALUE_W-1:0] max_r, max_nxt;
  logic [FIELD_W-1:0]        pos_r, pos_nxt;
  logic [FIELD_W-1:0]        pos_inc;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify and update sequence tracking
  always_comb begin
    pos_inc     = (pos_r < POS_MAX) ? pos_r + FIELD_W'(1) : pos_r;
    max_nxt     = max_r;
    pos_nxt     = pos_r;
    q_job.value = in_data.value;
    q_job.kind  = K_NORMAL;
    q_job.span  = '0;
    if (in_data.first) begin
      q_job.kind = K_FIRST;
      max_nxt    = in_data.value;
      pos_nxt    = '0;
    end else begin
      pos_nxt = pos_inc;
      if (in_data.value > max_r) begin
        q_job.kind = K_NEWMAX;
        max_nxt    = in_data.value;
        q_job.span = ({13'd0, pos_inc} > CNT_MAX) ? CNT_MAX[FIELD_W-1:0] : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      pos_r <= '0;
    end else if (q_push) begin
      max_r <= max_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/sss_queue.sv */
// ----------------------------------------------------------------------------
// sss_queue: short job queue between front and back
// Lets the front keep taking words while the back walks the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sss_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output sss_pkg::job_t      head_job
);

  import sss_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/sss_back.sv */
// ----------------------------------------------------------------------------
// sss_back: stack engine of the span sum stack
// Pops covered entries, pushes the new entry, reduces the count modulo
// one million one bit position a cycle and updates the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_back #(
  parameter int STACK_DEPTH = 128,
  parameter int COUNT_BITS  = 20
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire sss_pkg::job_t q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sss_pkg::out_t      out_data
);

  import sss_pkg::*;

  localparam int AW        = $clog2(STACK_DEPTH);
  localparam int LW        = $clog2(STACK_DEPTH + 1);
  localparam int RAM_W     = VALUE_W + COUNT_BITS;
  localparam int RED_W     = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
  localparam int RED_STEPS = (COUNT_BITS > FIELD_W - 1) ? COUNT_BITS - (FIELD_W - 1) : 1;
  localparam int KW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  // count plus entry count plus one, saturating
  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b} + (COUNT_BITS + 1)'(1);
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  b_state_t                  state_r, state_nxt;
  logic [LW-1:0]             level_r, level_nxt;
  logic [FIELD_W-1:0]        sum_r, sum_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_t                      out_data_r, out_data_nxt;
  logic signed [VALUE_W-1:0] v_r, v_nxt;
  logic signed [VALUE_W-1:0] top_v_r, top_v_nxt;
  logic [COUNT_BITS-1:0]     top_c_r, top_c_nxt;
  logic [COUNT_BITS-1:0]     acc_r, acc_nxt;
  logic [RED_W-1:0]          red_r, red_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic                      ovf_r, ovf_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [RAM_W-1:0]          ram_wdata, ram_rdata;

  logic signed [VALUE_W-1:0] rd_v;
  logic [COUNT_BITS-1:0]     rd_c;
  logic [LW-1:0]             lvl_dec, lvl_dec2;
  logic                      ge_top, ge_rd, out_free, idle_to_pop;
  logic [RED_W-1:0]          red_sub;
  logic [FIELD_W:0]          sum_add;
  logic [FIELD_W-1:0]        sum_fin;
  logic [RED_W-1:0]          acc_ext;
  logic [FIELD_W-1:0]        covered;

  logic                      push_en;
  logic [LW-1:0]             push_base;
  logic signed [VALUE_W-1:0] push_v;
  logic [COUNT_BITS-1:0]     push_c;

  sss_ram #(
    .WIDTH (RAM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared conditions
  assign rd_v        = $signed(ram_rdata[RAM_W-1:COUNT_BITS]);
  assign rd_c        = ram_rdata[COUNT_BITS-1:0];
  assign lvl_dec     = level_r - LW'(1);
  assign lvl_dec2    = level_r - LW'(2);
  assign ge_top      = (q_job.value >= top_v_r);
  assign ge_rd       = (v_r >= rd_v);
  assign out_free    = !out_valid_r || !out_stall;
  assign idle_to_pop = (q_job.kind == K_NORMAL) && (level_r != '0) && ge_top &&
                       (lvl_dec != '0);
  assign red_sub     = RED_W'(SUM_MODULUS) << k_r;
  assign sum_add     = {1'b0, sum_r} + {1'b0, red_r[FIELD_W-1:0]};
  assign sum_fin     = (sum_add >= {1'b0, SUM_MODULUS}) ?
                       FIELD_W'(sum_add - {1'b0, SUM_MODULUS}) : sum_add[FIELD_W-1:0];
  assign acc_ext     = RED_W'(acc_r);
  assign covered     = (acc_ext > RED_W'(OUT_MAX)) ? OUT_MAX : acc_ext[FIELD_W-1:0];

  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = idle_to_pop ? B_POP : B_RED;
        end
      end
      B_POP: begin
        if (!(ge_rd && lvl_dec != '0)) begin
          state_nxt = B_RED;
        end
      end
      B_RED: begin
        if (k_r == '0) begin
          state_nxt = B_ADD;
        end
      end
      B_ADD: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and stack access
  always_comb begin
    level_nxt     = level_r;
    sum_nxt       = sum_r;
    v_nxt         = v_r;
    top_v_nxt     = top_v_r;
    top_c_nxt     = top_c_r;
    acc_nxt       = acc_r;
    red_nxt       = red_r;
    k_nxt         = k_r;
    ovf_nxt       = ovf_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    push_en       = 1'b0;
    push_base     = '0;
    push_v        = v_r;
    push_c        = '0;
    ram_raddr     = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          v_nxt   = q_job.value;
          push_v  = q_job.value;
          ovf_nxt = 1'b0;
          case (q_job.kind)
            K_FIRST: begin
              sum_nxt = '0;
              acc_nxt = '0;
              push_en = 1'b1;
            end
            K_NEWMAX: begin
              acc_nxt = COUNT_BITS'(q_job.span);
              push_en = 1'b1;
              push_c  = COUNT_BITS'(q_job.span);
            end
            K_NORMAL: begin
              if (level_r == '0 || !ge_top) begin
                acc_nxt   = '0;
                push_en   = 1'b1;
                push_base = level_r;
              end else begin
                acc_nxt = sat_add('0, top_c_r);
                if (lvl_dec == '0) begin
                  push_en = 1'b1;
                  push_c  = acc_nxt;
                end else begin
                  level_nxt = lvl_dec;
                  ram_raddr = lvl_dec2[AW-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      B_POP: begin
        if (ge_rd) begin
          acc_nxt = sat_add(acc_r, rd_c);
          if (lvl_dec == '0) begin
            push_en = 1'b1;
            push_c  = acc_nxt;
          end else begin
            level_nxt = lvl_dec;
            ram_raddr = lvl_dec2[AW-1:0];
          end
        end else begin
          push_en   = 1'b1;
          push_base = level_r;
          push_c    = acc_r;
        end
      end
      B_RED: begin
        if (red_r >= red_sub) begin
          red_nxt = red_r - red_sub;
        end
        if (k_r != '0) begin
          k_nxt = k_r - KW'(1);
        end
      end
      B_ADD: begin
        if (out_free) begin
          sum_nxt               = sum_fin;
          out_valid_nxt         = 1'b1;
          out_data_nxt.covered  = covered;
          out_data_nxt.total    = sum_fin;
          out_data_nxt.overflow = ovf_r;
        end
      end
      default: ;
    endcase

    // push of the new entry, dropped when the stack is full
    if (push_en) begin
      red_nxt = RED_W'(acc_nxt);
      k_nxt   = KW'(RED_STEPS - 1);
      if (push_base == LW'(STACK_DEPTH)) begin
        ovf_nxt = 1'b1;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = push_base[AW-1:0];
        ram_wdata = {push_v, push_c};
        level_nxt = push_base + LW'(1);
        top_v_nxt = push_v;
        top_c_nxt = push_c;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      level_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    v_r        <= v_nxt;
    top_v_r    <= top_v_nxt;
    top_c_r    <= top_c_nxt;
    acc_r      <= acc_nxt;
    red_r      <= red_nxt;
    k_r        <= k_nxt;
    ovf_r      <= ovf_nxt;
  end

endmodule

`default_nettype wire

/* src/stock_span_sum_stack.sv */
// ----------------------------------------------------------------------------
// stock_span_sum_stack: span counts over a monotonic stack with running sum
//
// Input words carry a signed 32-bit value and a first flag that opens a new
// sequence. Each input word gives exactly one result word: covered (span of
// earlier items), total (running sum of spans modulo one million) and
// overflow (stack full, entry dropped).
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The front takes a word in every cycle while its two-entry job
// queue has room, so input is held off only when the queue is full.
// The back walks the stack through one memory read port: per word it
// starts, compares entries below the top while popping, reduces the
// count modulo one million one bit position at a time and posts the
// result, waiting in that last step while the result side stalls. A
// stalled result waits in the output register while the front keeps
// filling the queue. Reset empties the stack, clears the maximum,
// position and sum, and drops all queued and pending words.
// ----------------------------------------------------------------------------
`default_nettype none

module stock_span_sum_stack #(
  parameter int STACK_DEPTH = sss_pkg::STACK_DEPTH_DEF,
  parameter int COUNT_BITS  = sss_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sss_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sss_pkg::out_t      out_data
);

  import sss_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  job_t push_job, head_job;

  // front: accept and classify
  sss_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // job queue
  sss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // back: stack engine
  sss_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // front never writes a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
    else $error("job written into full queue");

  // back only takes a job that is there
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("job taken from empty queue");

  // running sum stays reduced
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid |-> (out_data.total < SUM_MODULUS))
    else $error("total not below modulus");

endmodule

`default_nettype wire

/* dv/tb_stock_span_sum_stack.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stock_span_sum_stack: self-checking bench for the span sum stack
// Sends signed value words with sequence-start flags and keeps its own
// monotonic stack to work out the span, running sum and overflow of every
// word. Result words are checked in order against that prediction while both
// channels idle at random, including a long back-pressure hold.
// ----------------------------------------------------------------------------
module tb_stock_span_sum_stack;
  import sss_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  // about 1750 words plus idling; taken many times over
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 250;
  localparam int IDLE_PCT     = 33;
  localparam int WRAP_WORDS   = 1470;
  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int CNT_BITS     = COUNT_BITS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;

  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;

  typedef enum int {
    SHAPE_WIDE,
    SHAPE_NARROW,
    SHAPE_WALK,
    SHAPE_SAW
  } shape_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  bit no_gaps;
  bit hold_request;
  int err_count;
  int word_count;
  int seq_count;
  int ovf_count;
  int wrap_count;
  longint unsigned peak_span;

  // local copy of the span stack and sequence state
  logic signed [VALUE_W-1:0] span_val [DEPTH];
  longint unsigned           span_cnt [DEPTH];
  int                        span_lvl  = 0;
  logic signed [VALUE_W-1:0] seq_max   = '0;
  longint unsigned           seq_pos   = 0;
  longint unsigned           span_sum  = 0;
  out_t                      span_expect_q [$];

  stock_span_sum_stack dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  function automatic longint unsigned sat_span(input longint unsigned c);
    return (c > CNT_MAX) ? CNT_MAX : c;
  endfunction

  // advance the local stack by one word and return its result word
  function automatic out_t predict_span(input logic signed [VALUE_W-1:0] v, input logic f);
    out_t            r;
    longint unsigned acc;
    longint unsigned old_sum;
    r   = '0;
    acc = 0;
    if (f) begin
      span_lvl = 0;
      seq_max  = v;
      seq_pos  = 0;
      span_sum = 0;
      seq_count++;
    end else begin
      if (seq_pos < POS_MAX) seq_pos++;
      if (v > seq_max) begin
        // new maximum covers the whole sequence so far
        acc      = sat_span(seq_pos);
        span_lvl = 0;
        seq_max  = v;
      end else begin
        while (span_lvl > 0 && v >= span_val[span_lvl-1]) begin
          acc = sat_span(acc + span_cnt[span_lvl-1] + 1);
          span_lvl--;
        end
      end
      old_sum  = span_sum;
      span_sum = (span_sum + acc % SUM_MODULUS) % SUM_MODULUS;
      if (span_sum < old_sum) wrap_count++;
    end
    // push, or drop when full
    if (span_lvl >= DEPTH) begin
      r.overflow = 1'b1;
      ovf_count++;
    end else begin
      span_val[span_lvl] = v;
      span_cnt[span_lvl] = acc;
      span_lvl++;
    end
    r.covered = (acc > OUT_MAX) ? OUT_MAX : acc[FIELD_W-1:0];
    r.total   = span_sum[FIELD_W-1:0];
    if (acc > peak_span) peak_span = acc;
    return r;
  endfunction

  // offer one word after a random gap, record its result once taken
  task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic f);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_t'{value: v, first: f};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    span_expect_q.push_back(predict_span(v, f));
    word_count++;
    @(negedge clk);
  endtask

  // result side stalls, with a long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // compare each taken result word with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (span_expect_q.size() == 0) begin
        $error("result word with nothing pending: covered %0d total %0d overflow %0d",
               out_data.covered, out_data.total, out_data.overflow);
        err_count++;
      end else begin
        want = span_expect_q.pop_front();
        if (out_data.covered !== want.covered) begin
          $error("covered mismatch: expected %0d, actual %0d", want.covered, out_data.covered);
          err_count++;
        end
        if (out_data.total !== want.total) begin
          $error("total mismatch: expected %0d, actual %0d", want.total, out_data.total);
          err_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow mismatch: expected %0d, actual %0d",
                 want.overflow, out_data.overflow);
          err_count++;
        end
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] next_value(input shape_t shape,
                                                            input logic signed [VALUE_W-1:0] prev);
    case (shape)
      SHAPE_WIDE:   return $urandom;
      SHAPE_NARROW: return $signed($urandom_range(16)) - 8;
      SHAPE_WALK:   return prev + $urandom_range(40) - 20;
      SHAPE_SAW: begin
        // mostly falling, with an occasional jump up
        if ($urandom_range(7) == 0) return prev + $urandom_range(1, 5000);
        return prev - $urandom_range(60);
      end
      default:      return prev;
    endcase
  endfunction

  // sequences of random shape and length, some run on or broken early
  task automatic run_sequences(input int n_words);
    int                        left;
    int                        len;
    int                        i;
    shape_t                    shape;
    logic signed [VALUE_W-1:0] v;
    logic                      f;
    left = n_words;
    while (left > 0) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
      shape = shape_t'($urandom_range(3));
      v     = $urandom;
      if ($urandom_range(3) == 0)
        v = $urandom_range(1) ? V_MAX - $urandom_range(30) : V_MIN + $urandom_range(30);
      f = ($urandom_range(9) != 0);
      for (i = 0; i < len && left > 0; i++) begin
        send_word(v, f);
        left--;
        v = next_value(shape, v);
        f = ($urandom_range(49) == 0);
      end
    end
  endtask

  // reset state behaves as an open sequence with max 0 and an empty stack
  task automatic test_before_first();
    send_word(0, 1'b0);
    send_word(-5, 1'b0);
    send_word(-5, 1'b0);
    send_word(V_MIN, 1'b0);
    send_word(3, 1'b0);
    send_word(3, 1'b0);
  endtask

  // value extremes, ties with the maximum and starts at both ends
  task automatic test_extremes();
    send_word(V_MIN, 1'b1);
    send_word(V_MIN, 1'b0);
    send_word(V_MAX, 1'b0);
    send_word(V_MAX, 1'b0);
    send_word(-1, 1'b0);
    send_word(0, 1'b0);
    send_word(V_MIN, 1'b0);
    send_word(V_MAX, 1'b1);
    send_word(-1, 1'b0);
    send_word(-2, 1'b0);
    send_word(-1, 1'b0);
    send_word(V_MAX, 1'b0);
    send_word(-1, 1'b1);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shaaaa_aaaa, 1'b0);
    send_word(32'sh5555_5555, 1'b0);
  endtask

  // strictly falling run deeper than the stack, then pops over dropped words
  task automatic test_stack_overflow();
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] top;
    logic signed [VALUE_W-1:0] mid;
    int                        i;
    v   = 32'sh4000_0000 + $urandom_range(1000);
    top = v;
    mid = v;
    send_word(v, 1'b1);
    for (i = 0; i < DEPTH + 12; i++) begin
      v = v - $urandom_range(1, 1000);
      if (i == DEPTH / 2) mid = v;
      send_word(v, 1'b0);
    end
    send_word(v, 1'b0);
    send_word(mid, 1'b0);
    send_word(top, 1'b0);
    send_word(top + 1, 1'b0);
  endtask

  // one long mostly rising sequence so the running sum passes one million
  task automatic test_sum_wrap();
    logic signed [VALUE_W-1:0] v;
    int                        i;
    v = $signed($urandom_range(1000)) - 1000000;
    send_word(v, 1'b1);
    for (i = 0; i < WRAP_WORDS; i++) begin
      if ($urandom_range(59) == 0) v = v - $urandom_range(1, 3);
      else v = v + $urandom_range(4);
      send_word(v, 1'b0);
    end
  endtask

  task automatic test_random_streams();
    run_sequences(40);
  endtask

  // both sides busy every cycle
  task automatic test_steady_flow();
    no_gaps = 1'b1;
    run_sequences(50);
    no_gaps = 1'b0;
  endtask

  // result side held off while words keep coming
  task automatic test_backpressure();
    hold_request = 1'b1;
    run_sequences(20);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_before_first();
    test_extremes();
    test_stack_overflow();
    test_sum_wrap();
    test_random_streams();
    test_steady_flow();
    test_backpressure();

    in_valid <= 1'b0;
    wait (span_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d words over %0d sequences: %0d dropped on a full stack, %0d sum wraps",
             word_count, seq_count, ovf_count, wrap_count);
    $display("largest span %0d, result side held for %0d cycles once",
             peak_span, HOLD_CYCLES);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("timeout with %0d result words outstanding", span_expect_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
